@@ hw/rtl/pmt_pkg.sv @@
`default_nettype none

package pmt_pkg;

    localparam logic [7:0] STAT_READY   = 8'h01;
    localparam logic [7:0] STAT_AUX     = 8'h20;
    localparam logic [7:0] HDR_ALWAYS1  = 8'h08;
    localparam logic [7:0] HDR_OVERFLOW = 8'hC0;

    localparam logic [2:0] CFG_MAX_DELTA     = 3'd0;
    localparam logic [2:0] CFG_X_GAIN        = 3'd1;
    localparam logic [2:0] CFG_Y_GAIN        = 3'd2;
    localparam logic [2:0] CFG_SCREEN_WIDTH  = 3'd3;
    localparam logic [2:0] CFG_SCREEN_HEIGHT = 3'd4;
    localparam logic [2:0] CFG_WHEEL_MODE    = 3'd5;

    localparam logic [7:0] MAX_DELTA_RST = 8'd200;
    localparam logic [7:0] GAIN_RST      = 8'd1;

    localparam int QDEPTH = 2;
    localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;

    typedef enum logic [1:0] {
        PH_HEADER = 2'd0,
        PH_X      = 2'd1,
        PH_Y      = 2'd2,
        PH_WHEEL  = 2'd3
    } phase_t;

    typedef enum logic {
        KIND_POSITION = 1'b0,
        KIND_SCROLL   = 1'b1
    } kind_t;

    typedef struct packed {
        kind_t      kind;
        logic [2:0] buttons;
        logic [7:0] dx;
        logic [7:0] dy;
        logic [7:0] wheel;
    } cmd_t;

    typedef struct packed {
        logic [7:0]  max_delta;
        logic [7:0]  x_gain;
        logic [7:0]  y_gain;
        logic [15:0] screen_width;
        logic [15:0] screen_height;
        logic        wheel_mode;
    } cfg_t;

endpackage

`default_nettype wire

@@ hw/rtl/pmt_front.sv @@
`default_nettype none

module pmt_front (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    input  wire logic [7:0]    status_byte,
    input  wire logic [7:0]    data_byte,
    input  wire logic          wheel_mode,
    output pmt_pkg::cmd_t      cmd,
    output logic               push
);
    import pmt_pkg::*;

    phase_t     phase_reg, phase_next;
    logic [7:0] dx_reg, dx_next;
    logic [7:0] dy_reg, dy_next;
    logic [2:0] btn_reg, btn_next;
    logic       byte_ok;
    logic       hdr_bad;

    assign byte_ok = in_valid && ((status_byte & STAT_READY) != 8'h00)
                     && ((status_byte & STAT_AUX) != 8'h00);
    assign hdr_bad = (data_byte == 8'h00) || ((data_byte & HDR_ALWAYS1) == 8'h00)
                     || ((data_byte & HDR_OVERFLOW) != 8'h00);

    always_comb
    begin
        phase_next = phase_reg;
        if (byte_ok)
        begin
            unique case (phase_reg)
                PH_HEADER: phase_next = hdr_bad ? PH_HEADER : PH_X;
                PH_X:      phase_next = PH_Y;
                PH_Y:      phase_next = wheel_mode ? PH_WHEEL : PH_HEADER;
                PH_WHEEL:  phase_next = PH_HEADER;
                default:   phase_next = PH_HEADER;
            endcase
        end
    end

    always_comb
    begin
        dx_next   = dx_reg;
        dy_next   = dy_reg;
        btn_next  = btn_reg;
        push      = 1'b0;
        cmd.kind    = KIND_POSITION;
        cmd.buttons = btn_reg;
        cmd.dx      = dx_reg;
        cmd.dy      = dy_reg;
        cmd.wheel   = 8'h00;
        if (byte_ok)
        begin
            unique case (phase_reg)
                PH_HEADER:
                begin
                    dx_next = 8'h00;
                    dy_next = 8'h00;
                    if (!hdr_bad)
                        btn_next = data_byte[2:0];
                end
                PH_X:
                    dx_next = data_byte;
                PH_Y:
                begin
                    dy_next = data_byte;
                    cmd.dy  = data_byte;
                    push    = 1'b1;
                end
                PH_WHEEL:
                begin
                    cmd.kind  = KIND_SCROLL;
                    cmd.wheel = data_byte;
                    push      = 1'b1;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HEADER;
            dx_reg    <= 8'h00;
            dy_reg    <= 8'h00;
            btn_reg   <= 3'b000;
        end
        else
        begin
            phase_reg <= phase_next;
            dx_reg    <= dx_next;
            dy_reg    <= dy_next;
            btn_reg   <= btn_next;
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/pmt_queue.sv @@
`default_nettype none

module pmt_queue (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    input  wire pmt_pkg::cmd_t push_cmd,
    input  wire logic          pop,
    output pmt_pkg::cmd_t      head_cmd,
    output logic               full,
    output logic               empty
);
    import pmt_pkg::*;

    cmd_t              mem [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QPTR_W:0]   count_reg, count_next;

    assign full     = (count_reg == (QPTR_W+1)'(QDEPTH));
    assign empty    = (count_reg == '0);
    assign head_cmd = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_cmd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full || pop)
        else $error("queue write while full");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !empty)
        else $error("queue read while empty");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= (QPTR_W+1)'(QDEPTH))
        else $error("queue count out of range");

    a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (empty || full) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("queue pointers disagree with count");

endmodule

`default_nettype wire

@@ hw/rtl/pmt_back.sv @@
`default_nettype none

module pmt_back #(
    parameter int POS_BITS = 16
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire pmt_pkg::cfg_t cfg,
    input  wire pmt_pkg::cmd_t cmd,
    input  wire logic          cmd_valid,
    output logic               cmd_pop,
    output logic               out_valid,
    input  wire logic          out_ready,
    output logic [15:0]        pointer_x,
    output logic [15:0]        pointer_y,
    output logic [2:0]         buttons,
    output logic [7:0]         move_x,
    output logic [7:0]         move_y,
    output logic [7:0]         wheel_delta,
    output logic               report_kind
);
    import pmt_pkg::*;

    localparam int EW = (POS_BITS > 16) ? POS_BITS : 16;
    localparam int SW = EW + 3;
    localparam logic [EW-1:0] POS_MAX = EW'((64'd1 << POS_BITS) - 64'd1);

    function automatic logic [POS_BITS-1:0] move_axis(
        input logic [POS_BITS-1:0] pos,
        input logic [7:0]          raw,
        input logic [7:0]          gain,
        input logic [15:0]         limit,
        input logic                sub,
        input logic [7:0]          mdelta
    );
        logic signed [9:0]    d;
        logic signed [9:0]    m;
        logic signed [18:0]   sc;
        logic signed [SW-1:0] p;
        logic [EW-1:0]        hi;
        logic [EW-1:0]        res;
        d  = $signed({{2{raw[7]}}, raw});
        m  = $signed({2'b00, mdelta});
        if (d > m)
            d = m;
        if (d < -m)
            d = -m;
        sc = d * $signed({1'b0, gain});
        p  = $signed({3'b000, EW'(pos)});
        p  = sub ? (p - SW'(sc)) : (p + SW'(sc));
        hi = (EW'(limit) > POS_MAX) ? POS_MAX : EW'(limit);
        if (p < 0)
            res = '0;
        else if (p > $signed({3'b000, hi}))
            res = hi;
        else
            res = p[EW-1:0];
        return POS_BITS'(res);
    endfunction

    logic [POS_BITS-1:0] pos_x_reg, pos_x_next;
    logic [POS_BITS-1:0] pos_y_reg, pos_y_next;
    logic [EW-1:0]       ext_x;
    logic [EW-1:0]       ext_y;
    logic                out_valid_reg;

    assign cmd_pop = cmd_valid && (!out_valid_reg || out_ready);

    always_comb
    begin
        pos_x_next = pos_x_reg;
        pos_y_next = pos_y_reg;
        if (cmd_pop && (cmd.kind == KIND_POSITION))
        begin
            pos_x_next = move_axis(pos_x_reg, cmd.dx, cfg.x_gain, cfg.screen_width,
                                   1'b0, cfg.max_delta);
            pos_y_next = move_axis(pos_y_reg, cmd.dy, cfg.y_gain, cfg.screen_height,
                                   1'b1, cfg.max_delta);
        end
    end

    assign ext_x = EW'(pos_x_next);
    assign ext_y = EW'(pos_y_next);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_x_reg     <= '0;
            pos_y_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pos_x_reg <= pos_x_next;
            pos_y_reg <= pos_y_next;
            if (cmd_pop)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_pop)
        begin
            pointer_x   <= ext_x[15:0];
            pointer_y   <= ext_y[15:0];
            buttons     <= cmd.buttons;
            move_x      <= cmd.dx;
            move_y      <= cmd.dy;
            wheel_delta <= cmd.wheel;
            report_kind <= cmd.kind;
        end
    end

    assign out_valid = out_valid_reg;

    a_scroll_keeps_pos: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_pop && cmd.kind == KIND_SCROLL) |=> $stable(pos_x_reg) && $stable(pos_y_reg))
        else $error("scroll report moved the pointer");

    a_pos_wheel_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && report_kind == KIND_POSITION) |-> wheel_delta == 8'h00)
        else $error("position report carries scroll data");

    a_no_pop_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready) |-> !cmd_pop)
        else $error("command taken while output stalled");

endmodule

`default_nettype wire

@@ hw/rtl/ps2_mouse_packet_tracker_unit.sv @@
`default_nettype none
// PS/2 mouse packet tracker.
// s_* channel: one word per controller read, status byte and data byte.
// Words without data-ready and auxiliary status bits are dropped silently.
// Header, X and Y bytes (plus a scroll byte in wheel mode) form a packet; a
// position report leaves after the Y byte and a scroll report after the
// scroll byte. Other words produce no report.
// m_* channel: one report word, m_tuser gives the kind (0 position, 1 scroll).
// The command for a report is written into the queue and then into the output
// register, from which the m_* channel takes it.
// Throughput: one word per cycle while s_tready is high; the front decoder
// feeds a two-entry command queue and the back end updates the pointer with
// one multiply, add and clamp per axis.
// When m_tready is low the report holds, the queue fills, and s_tready drops
// once both queue entries are taken.
// Reset clears packet phase, pointer, buttons, deltas and queue, and loads
// max_delta 200, gains 1, screen size 0 and wheel mode off.
// cfg_we/cfg_index/cfg_data write a register per cycle; unknown indexes are
// ignored.

module ps2_mouse_packet_tracker_unit #(
    parameter int POS_BITS = 16
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,   // status_byte[7:0], data_byte[15:8]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // pointer_x[15:0], pointer_y[31:16], left_down[32], right_down[33],
    // middle_down[34], move_x[42:35], move_y[50:43], wheel_delta[58:51], zero
    output logic [63:0]      m_tdata,
    output logic [0:0]       m_tuser,   // report_kind[0]
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [15:0] cfg_data
);
    import pmt_pkg::*;

    cfg_t        cfg_reg;
    cmd_t        front_cmd;
    cmd_t        head_cmd;
    logic        push;
    logic        pop;
    logic        q_full;
    logic        q_empty;
    logic        in_take;
    logic [15:0] pointer_x;
    logic [15:0] pointer_y;
    logic [2:0]  buttons;
    logic [7:0]  move_x;
    logic [7:0]  move_y;
    logic [7:0]  wheel_delta;
    logic        report_kind;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.max_delta     <= MAX_DELTA_RST;
            cfg_reg.x_gain        <= GAIN_RST;
            cfg_reg.y_gain        <= GAIN_RST;
            cfg_reg.screen_width  <= 16'd0;
            cfg_reg.screen_height <= 16'd0;
            cfg_reg.wheel_mode    <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_MAX_DELTA:     cfg_reg.max_delta     <= cfg_data[7:0];
                CFG_X_GAIN:        cfg_reg.x_gain        <= cfg_data[7:0];
                CFG_Y_GAIN:        cfg_reg.y_gain        <= cfg_data[7:0];
                CFG_SCREEN_WIDTH:  cfg_reg.screen_width  <= cfg_data;
                CFG_SCREEN_HEIGHT: cfg_reg.screen_height <= cfg_data;
                CFG_WHEEL_MODE:    cfg_reg.wheel_mode    <= cfg_data[0];
                default: ;
            endcase
        end
    end

    assign s_tready = !q_full;
    assign in_take  = s_tvalid && !q_full;

    pmt_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_take),
        .status_byte (s_tdata[7:0]),
        .data_byte   (s_tdata[15:8]),
        .wheel_mode  (cfg_reg.wheel_mode),
        .cmd         (front_cmd),
        .push        (push)
    );

    pmt_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (front_cmd),
        .pop      (pop),
        .head_cmd (head_cmd),
        .full     (q_full),
        .empty    (q_empty)
    );

    pmt_back #(
        .POS_BITS (POS_BITS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .cmd         (head_cmd),
        .cmd_valid   (!q_empty),
        .cmd_pop     (pop),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .pointer_x   (pointer_x),
        .pointer_y   (pointer_y),
        .buttons     (buttons),
        .move_x      (move_x),
        .move_y      (move_y),
        .wheel_delta (wheel_delta),
        .report_kind (report_kind)
    );

    assign m_tdata = {5'b00000, wheel_delta, move_y, move_x, buttons, pointer_y, pointer_x};
    assign m_tuser = report_kind;

endmodule

`default_nettype wire
